@@ design/pas_pkg.sv @@
// shared types and constants of the priority aging scheduler
package pas_pkg;

    localparam int SLOT_W = 4;
    localparam int PRIO_W = 6;
    localparam int AGE_W  = 6;
    localparam int EFF_W  = 7;

    localparam logic signed [EFF_W-1:0] PRIO_LIMIT = 7'sd20;
    localparam logic signed [EFF_W-1:0] AGE_FLOOR  = -7'sd20;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PICK   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_OK     = 2'd0,
        RES_EMPTY  = 2'd1,
        RES_DUP    = 2'd2,
        RES_ABSENT = 2'd3
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_TGT,
        ST_LD_TGT,
        ST_SCAN,
        ST_SWEEP,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic capture;
        logic insert;
        logic scan_clear;
        logic tgt_read;
        logic tgt_load;
        logic scan_step;
        logic sweep_step;
        logic out_load;
        logic retire;
        logic win;
        res_t res;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic slot_ok;
        logic slot_ready;
        logic empty;
        logic last;
        logic out_busy;
    } sts_t;

endpackage

@@ design/pas_ctrl.sv @@
// controller state machine of the priority aging scheduler
module pas_ctrl
    import pas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    res_t   res_reg, res_next;
    logic   win_reg, win_next;
    logic   drop_reg, drop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= RES_OK;
            win_reg   <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
            win_reg   <= win_next;
            drop_reg  <= drop_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        win_next   = win_reg;
        drop_next  = drop_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                res_next   = RES_OK;
                win_next   = 1'b0;
                drop_next  = 1'b0;
                state_next = ST_RESPOND;
                case (sts.op)
                    OP_INSERT:
                    begin
                        if (!sts.slot_ok || sts.slot_ready)
                            res_next = RES_DUP;
                    end
                    OP_REMOVE:
                    begin
                        if (!sts.slot_ok || !sts.slot_ready)
                            res_next = RES_ABSENT;
                        else
                        begin
                            drop_next  = 1'b1;
                            state_next = ST_RD_TGT;
                        end
                    end
                    OP_PICK:
                    begin
                        if (sts.empty)
                            res_next = RES_EMPTY;
                        else
                        begin
                            win_next   = 1'b1;
                            drop_next  = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            ST_RD_TGT:  state_next = ST_LD_TGT;
            ST_LD_TGT:  state_next = ST_SWEEP;
            ST_SCAN:
            begin
                if (sts.last)
                    state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (sts.last)
                    state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.res  = res_reg;
        cmd.win  = win_reg;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECODE:
            begin
                cmd.insert     = (sts.op == OP_INSERT) && sts.slot_ok && !sts.slot_ready;
                cmd.scan_clear = (sts.op == OP_PICK) && !sts.empty;
            end
            ST_RD_TGT:  cmd.tgt_read   = 1'b1;
            ST_LD_TGT:  cmd.tgt_load   = 1'b1;
            ST_SCAN:    cmd.scan_step  = 1'b1;
            ST_SWEEP:   cmd.sweep_step = 1'b1;
            ST_RESPOND:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.retire   = drop_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ design/pas_dp.sv @@
// datapath of the priority aging scheduler: slot tables, scan unit and result register
module pas_dp
    import pas_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [1:0]               operation,
    input  logic [SLOT_W-1:0]        slot,
    input  logic signed [PRIO_W-1:0] priority_req,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [SLOT_W-1:0]        chosen_slot,
    output logic signed [PRIO_W-1:0] chosen_priority
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // slot tables, one entry per slot
    logic signed [PRIO_W-1:0] prio_mem [SLOTS];
    logic [AGE_W-1:0]         age_mem  [SLOTS];
    logic [IW-1:0]            rank_mem [SLOTS];

    logic signed [PRIO_W-1:0] rd_prio_reg;
    logic [AGE_W-1:0]         rd_age_reg;
    logic [IW-1:0]            rd_rank_reg;

    op_t                      op_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic signed [PRIO_W-1:0] preq_reg;

    logic [SLOTS-1:0] valid_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    cnt_reg;
    logic [IW-1:0]    proc_reg;
    logic             found_reg;
    logic             age_en_reg;

    logic [IW-1:0]            best_slot_reg;
    logic signed [PRIO_W-1:0] best_prio_reg;
    logic signed [EFF_W-1:0]  best_eff_reg;
    logic [IW-1:0]            best_rank_reg;

    logic                     out_valid_reg;
    res_t                     status_reg;
    logic [SLOT_W-1:0]        chosen_slot_reg;
    logic signed [PRIO_W-1:0] chosen_prio_reg;

    logic [IW-1:0]            slot_idx;
    logic [IW-1:0]            rd_addr;
    logic signed [EFF_W-1:0]  preq_ext;
    logic signed [PRIO_W-1:0] prio_clean;
    logic signed [EFF_W-1:0]  cur_eff;
    logic                     cur_live;
    logic                     better;
    logic                     last;
    logic                     mem_we;
    logic [IW-1:0]            wr_addr;
    logic signed [PRIO_W-1:0] wr_prio;
    logic [AGE_W-1:0]         wr_age;
    logic [IW-1:0]            wr_rank;

    assign slot_idx   = IW'(slot_reg);
    assign preq_ext   = {preq_reg[PRIO_W-1], preq_reg};
    assign prio_clean = (preq_ext > -PRIO_LIMIT && preq_ext < PRIO_LIMIT) ? preq_reg : '0;
    assign last       = (cnt_reg == CW'(SLOTS));
    assign cur_eff    = {rd_prio_reg[PRIO_W-1], rd_prio_reg} - {1'b0, rd_age_reg};
    assign cur_live   = (cnt_reg != '0) && valid_reg[proc_reg];

    always_comb
    begin
        if (cmd.tgt_read)
            rd_addr = slot_idx;
        else if (last)
            rd_addr = '0;
        else
            rd_addr = cnt_reg[IW-1:0];
    end

    // strict order: effective priority, then static priority, then arrival
    assign better = !found_reg || (cur_eff < best_eff_reg) ||
                    ((cur_eff == best_eff_reg) &&
                     ((rd_prio_reg < best_prio_reg) ||
                      ((rd_prio_reg == best_prio_reg) && (rd_rank_reg < best_rank_reg))));

    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = slot_idx;
        wr_prio = prio_clean;
        wr_age  = '0;
        wr_rank = IW'(count_reg);
        if (cmd.insert)
            mem_we = 1'b1;
        else if (cmd.sweep_step && cur_live && (proc_reg != best_slot_reg))
        begin
            mem_we  = 1'b1;
            wr_addr = proc_reg;
            wr_prio = rd_prio_reg;
            wr_age  = (age_en_reg && cur_eff > AGE_FLOOR) ? rd_age_reg + 1'b1 : rd_age_reg;
            wr_rank = (rd_rank_reg > best_rank_reg) ? rd_rank_reg - 1'b1 : rd_rank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prio_mem[wr_addr] <= wr_prio;
            age_mem[wr_addr]  <= wr_age;
            rank_mem[wr_addr] <= wr_rank;
        end
        rd_prio_reg <= prio_mem[rd_addr];
        rd_age_reg  <= age_mem[rd_addr];
        rd_rank_reg <= rank_mem[rd_addr];
        proc_reg    <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            age_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.insert)
            begin
                valid_reg[slot_idx] <= 1'b1;
                count_reg           <= count_reg + 1'b1;
            end
            else if (cmd.retire)
            begin
                valid_reg[best_slot_reg] <= 1'b0;
                count_reg                <= count_reg - 1'b1;
            end

            if (cmd.scan_clear)
            begin
                cnt_reg    <= '0;
                found_reg  <= 1'b0;
                age_en_reg <= 1'b1;
            end
            else if (cmd.tgt_load)
            begin
                cnt_reg    <= '0;
                age_en_reg <= 1'b0;
            end
            else if (cmd.scan_step || cmd.sweep_step)
            begin
                cnt_reg <= last ? '0 : cnt_reg + 1'b1;
                if (cmd.scan_step && cur_live && better)
                    found_reg <= 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(operation);
            slot_reg <= slot;
            preq_reg <= priority_req;
        end
        if (cmd.tgt_load)
        begin
            best_rank_reg <= rd_rank_reg;
            best_slot_reg <= slot_idx;
        end
        else if (cmd.scan_step && cur_live && better)
        begin
            best_slot_reg <= proc_reg;
            best_prio_reg <= rd_prio_reg;
            best_eff_reg  <= cur_eff;
            best_rank_reg <= rd_rank_reg;
        end
        if (cmd.out_load)
        begin
            status_reg      <= cmd.res;
            chosen_slot_reg <= cmd.win ? SLOT_W'(best_slot_reg) : '0;
            chosen_prio_reg <= cmd.win ? best_prio_reg : '0;
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.op         = op_reg;
        sts.slot_ok    = int'(slot_reg) < SLOTS;
        sts.slot_ready = valid_reg[slot_idx];
        sts.empty      = (count_reg == '0);
        sts.last       = last;
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign chosen_slot     = chosen_slot_reg;
    assign chosen_priority = chosen_prio_reg;

endmodule

@@ design/priority_aging_scheduler.sv @@
// top level of the priority aging scheduler
// Usage: one item per command on the input channel (in_valid/in_ready with operation,
// slot, priority_req); exactly one result per item on the output channel
// (out_valid/out_ready with status, chosen_slot, chosen_priority).
// Operations: insert a slot with a static priority, remove a slot, pick the slot with
// the least static priority minus age; the pick ages the other ready slots (until
// their effective priority reaches AGE_FLOOR) and retires the winner.
// One item is worked on at a time; in_ready is high only while the controller idles.
// Insert, no-op and refused requests do not walk the slot tables. The single read
// port of the tables sets the pace otherwise: a pick walks them once to select and
// once to age and re-rank, a remove walks them once to re-rank.
// The result is registered; while the receiver stalls it holds, and the finished
// next result waits in the controller until the output register frees.
// Reset empties the ready set and the output register; table contents are not
// cleared, entries are only used for slots that have been inserted.
module priority_aging_scheduler
    import pas_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               operation,
    input  logic [SLOT_W-1:0]        slot,
    input  logic signed [PRIO_W-1:0] priority_req,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [SLOT_W-1:0]        chosen_slot,
    output logic signed [PRIO_W-1:0] chosen_priority
);

    cmd_t cmd;
    sts_t sts;

    pas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pas_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .operation       (operation),
        .slot            (slot),
        .priority_req    (priority_req),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .chosen_slot     (chosen_slot),
        .chosen_priority (chosen_priority)
    );

    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (sts.slot_ok && !sts.slot_ready))
        else $error("insert of a slot that is already ready");

    a_retire_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.retire |-> !sts.empty)
        else $error("retire with an empty ready set");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result loaded over a stalled result");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in work");

endmodule

@@ bench/priority_aging_scheduler_tb.sv @@
// testbench of the priority aging scheduler: directed table, random traffic, predictor check
module priority_aging_scheduler_tb
    import pas_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS      = 16;
    localparam int RANDOM_ITEMS = 1225;
    localparam int QUIET_TAIL   = 150;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        res_t                     st;
        logic [SLOT_W-1:0]        slot;
        logic signed [PRIO_W-1:0] prio;
    } sched_result_t;

    typedef struct packed {
        op_t                      op;
        logic [SLOT_W-1:0]        slot;
        logic signed [PRIO_W-1:0] prio;
        logic                     typed;
        sched_result_t            want;
    } dir_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               operation;
    logic [SLOT_W-1:0]        slot;
    logic signed [PRIO_W-1:0] priority_req;
    logic                     out_valid;
    logic                     out_ready = 1'b1;
    logic [1:0]               status;
    logic [SLOT_W-1:0]        chosen_slot;
    logic signed [PRIO_W-1:0] chosen_priority;

    // predicted ready set
    bit  rq_ready [N_SLOTS];
    int  rq_prio  [N_SLOTS];
    int  rq_age   [N_SLOTS];
    int  rq_rank  [N_SLOTS];
    int  rq_count;

    sched_result_t replies_due[$];
    dir_row_t      directed_rows[$];
    logic          row_typed;
    sched_result_t row_want;
    bit            quiet = 1'b0;
    int            sink_hold = 0;
    int            mismatches = 0;
    int            stuck_cycles = 0;

    priority_aging_scheduler #(.SLOTS(N_SLOTS)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .slot            (slot),
        .priority_req    (priority_req),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .chosen_slot     (chosen_slot),
        .chosen_priority (chosen_priority)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic dir_row_t row(input op_t op, input logic [SLOT_W-1:0] s,
                                     input logic signed [PRIO_W-1:0] p, input logic typed,
                                     input res_t st, input logic [SLOT_W-1:0] cs,
                                     input logic signed [PRIO_W-1:0] cp);
        dir_row_t r;
        r.op        = op;
        r.slot      = s;
        r.prio      = p;
        r.typed     = typed;
        r.want.st   = st;
        r.want.slot = cs;
        r.want.prio = cp;
        return r;
    endfunction

    task automatic retire_slot(input int s);
        int r;
        r = rq_rank[s];
        rq_ready[s] = 1'b0;
        rq_age[s]   = 0;
        for (int i = 0; i < N_SLOTS; i++)
            if (rq_ready[i] && rq_rank[i] > r)
                rq_rank[i]--;
        if (rq_count > 0)
            rq_count--;
    endtask

    task automatic advance_ready_set(input op_t op, input logic [SLOT_W-1:0] s,
                                     input logic signed [PRIO_W-1:0] p,
                                     output sched_result_t res);
        int  pv;
        int  eff;
        int  beff;
        int  best;
        bit  found;
        res = '{RES_OK, '0, '0};
        pv  = p;
        case (op)
            OP_INSERT:
            begin
                if (rq_ready[s])
                    res.st = RES_DUP;
                else
                begin
                    rq_ready[s] = 1'b1;
                    // out-of-range requests fall back to priority zero
                    rq_prio[s]  = (pv > -int'(PRIO_LIMIT) && pv < int'(PRIO_LIMIT)) ? pv : 0;
                    rq_age[s]   = 0;
                    rq_rank[s]  = rq_count;
                    rq_count++;
                end
            end
            OP_REMOVE:
            begin
                if (!rq_ready[s])
                    res.st = RES_ABSENT;
                else
                    retire_slot(s);
            end
            OP_PICK:
            begin
                best  = 0;
                beff  = 0;
                found = 1'b0;
                for (int i = 0; i < N_SLOTS; i++)
                begin
                    if (!rq_ready[i])
                        continue;
                    eff = rq_prio[i] - rq_age[i];
                    if (!found || eff < beff ||
                        (eff == beff && (rq_prio[i] < rq_prio[best] ||
                         (rq_prio[i] == rq_prio[best] && rq_rank[i] < rq_rank[best]))))
                    begin
                        found = 1'b1;
                        best  = i;
                        beff  = eff;
                    end
                end
                if (!found)
                    res.st = RES_EMPTY;
                else
                begin
                    // aging is judged on the effective priority before this pick
                    for (int i = 0; i < N_SLOTS; i++)
                        if (rq_ready[i] && i != best &&
                            rq_prio[i] - rq_age[i] > int'(AGE_FLOOR))
                            rq_age[i]++;
                    res.slot = SLOT_W'(best);
                    res.prio = PRIO_W'(rq_prio[best]);
                    retire_slot(best);
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input sched_result_t want,
                                 input sched_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected status %0d slot %0d prio %0d, %s %0d %s %0d %s %0d",
                     $time, what, want.st, want.slot, want.prio,
                     "got status", got.st, "slot", got.slot, "prio", got.prio);
    endtask

    // a random slot that is in (or out of) the predicted ready set
    function automatic logic [SLOT_W-1:0] find_slot(input bit in_set);
        int start;
        start = $urandom_range(0, N_SLOTS - 1);
        for (int k = 0; k < N_SLOTS; k++)
            if (rq_ready[(start + k) % N_SLOTS] == in_set)
                return SLOT_W'((start + k) % N_SLOTS);
        return SLOT_W'(start);
    endfunction

    function automatic logic signed [PRIO_W-1:0] draw_priority();
        if ($urandom_range(0, 99) < 85)
            return PRIO_W'($urandom_range(0, 38) - 19);
        return PRIO_W'($urandom_range(0, 63));
    endfunction

    task automatic offer_item(input op_t op, input logic [SLOT_W-1:0] s,
                              input logic signed [PRIO_W-1:0] p, input logic typed,
                              input sched_result_t want);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        slot         <= s;
        priority_req <= p;
        row_typed    <= typed;
        row_want     <= want;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // receiver stalls in short bursts
    always @(negedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            sink_hold <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        sched_result_t pred;
        sched_result_t got;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                advance_ready_set(op_t'(operation), slot, priority_req, pred);
                replies_due.push_back(row_typed ? row_want : pred);
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                got = '{res_t'(status), chosen_slot, chosen_priority};
                if (replies_due.size() == 0)
                    flag_mismatch("no item pending", '0, got);
                else
                begin
                    pred = replies_due.pop_front();
                    if (got.st != pred.st || got.slot != pred.slot || got.prio != pred.prio)
                        flag_mismatch("field", pred, got);
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t no progress for %0d cycles", $time, STUCK_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        op_t                      op;
        logic [SLOT_W-1:0]        s;
        logic signed [PRIO_W-1:0] p;
        bit                       ins;
        int                       r;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_NOP;
        slot         = '0;
        priority_req = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        rq_count     = 0;
        foreach (rq_ready[i])
        begin
            rq_ready[i] = 1'b0;
            rq_prio[i]  = 0;
            rq_age[i]   = 0;
            rq_rank[i]  = 0;
        end

        directed_rows.push_back(row(OP_PICK,   4'd0,  6'sd0,   1'b1, RES_EMPTY,  4'd0,  6'sd0));
        directed_rows.push_back(row(OP_REMOVE, 4'd0,  6'sd0,   1'b1, RES_ABSENT, 4'd0,  6'sd0));
        directed_rows.push_back(row(OP_NOP,    4'd15, 6'sh20,  1'b1, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_INSERT, 4'd15, -6'sd19, 1'b1, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_INSERT, 4'd15, 6'sd5,   1'b1, RES_DUP,    4'd0,  6'sd0));
        directed_rows.push_back(row(OP_INSERT, 4'd0,  6'sd19,  1'b1, RES_OK,     4'd0,  6'sd0));
        // out-of-range priorities land at zero
        directed_rows.push_back(row(OP_INSERT, 4'd7,  6'sd31,  1'b1, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_INSERT, 4'd8,  6'sh20,  1'b1, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_INSERT, 4'd9,  -6'sd20, 1'b1, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_INSERT, 4'd10, 6'sd20,  1'b1, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_PICK,   4'd3,  6'sd7,   1'b1, RES_OK,     4'd15, -6'sd19));
        // equal effective priority, earliest arrival wins
        directed_rows.push_back(row(OP_PICK,   4'd0,  6'sd0,   1'b0, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_REMOVE, 4'd9,  6'sd0,   1'b1, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_REMOVE, 4'd9,  6'sd0,   1'b1, RES_ABSENT, 4'd0,  6'sd0));
        directed_rows.push_back(row(OP_INSERT, 4'd3,  6'sd4,   1'b1, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_INSERT, 4'd12, -6'sd19, 1'b1, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_PICK,   4'd0,  6'sd0,   1'b0, RES_OK,     4'd0,  6'sd0));
        directed_rows.push_back(row(OP_INSERT, 4'd5,  6'sd3,   1'b1, RES_OK,     4'd0,  6'sd0));
        for (int k = 0; k < 6; k++)
            directed_rows.push_back(row(OP_PICK, 4'd0, 6'sd0, 1'b0, RES_OK, 4'd0, 6'sd0));
        directed_rows.push_back(row(OP_NOP,    4'd0,  6'sd31,  1'b1, RES_OK,     4'd0,  6'sd0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            offer_item(directed_rows[k].op, directed_rows[k].slot, directed_rows[k].prio,
                       directed_rows[k].typed, directed_rows[k].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= RANDOM_ITEMS - QUIET_TAIL);
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                op = OP_NOP;
                s  = SLOT_W'($urandom_range(0, 15));
                p  = PRIO_W'($urandom_range(0, 63));
            end
            else if (r < 14)
            begin
                // noise: duplicates, absent removes, picks on an empty set
                op = op_t'($urandom_range(0, 2));
                s  = SLOT_W'($urandom_range(0, 15));
                p  = PRIO_W'($urandom_range(0, 63));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (rq_count == 0)
                    ins = 1'b1;
                else if (rq_count == N_SLOTS)
                    ins = 1'b0;
                else if (rq_count < 4)
                    ins = (r < 70);
                else if (rq_count > 12)
                    ins = (r < 25);
                else
                    ins = (r < 50);
                if (ins)
                begin
                    op = OP_INSERT;
                    s  = find_slot(1'b0);
                    p  = draw_priority();
                end
                else if ($urandom_range(0, 9) < 7)
                begin
                    op = OP_PICK;
                    s  = SLOT_W'($urandom_range(0, 15));
                    p  = PRIO_W'($urandom_range(0, 63));
                end
                else
                begin
                    op = OP_REMOVE;
                    s  = find_slot(1'b1);
                    p  = PRIO_W'($urandom_range(0, 63));
                end
            end
            offer_item(op, s, p, 1'b0, '0);
        end
        in_valid <= 1'b0;

        wait (replies_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
